>>> src/ptrt_pkg.sv
package ptrt_pkg;

  localparam int TagW  = 32;
  localparam int CtxW  = 32;
  localparam int CodeW = 32;
  localparam int RespW = 4;
  localparam int PortW = 2;

  localparam int SlotsDefault = 8;
  localparam int PortsDefault = 4;

  localparam logic [RespW-1:0] ErrCodeReset = 4'd4;
  localparam logic [TagW-1:0]  TagFirst     = 32'd1;

  // Item opcodes.
  localparam logic OP_CMD = 1'b0;
  localparam logic OP_STS = 1'b1;

  // Result destinations.
  localparam logic DEST_DISPATCH = 1'b0;
  localparam logic DEST_STATUS   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } scan_state_e;

  typedef struct packed {
    logic [TagW-1:0]  tag;
    logic [CtxW-1:0]  ctx;
    logic [PortW-1:0] port;
  } slot_entry_t;

  // Busy-flag update for one slot; the slot index travels alongside.
  typedef struct packed {
    logic set;
    logic clr;
  } tbl_ctl_t;

  // Scan outcome, valid in the cycle the result is committed.
  typedef struct packed {
    logic commit;
    logic hit;
  } scan_res_t;

endpackage

>>> src/ptrt_slot_table.sv
module ptrt_slot_table import ptrt_pkg::*; #(
  parameter int SLOTS = SlotsDefault,
  parameter int IdxW  = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tbl_ctl_t        ctl_i,
  input  logic [IdxW-1:0] wr_idx_i,
  input  slot_entry_t     wr_entry_i,
  input  logic [IdxW-1:0] rd_idx_i,
  output slot_entry_t     rd_entry_o,
  output logic            rd_busy_o
);

  slot_entry_t slot_mem_q [SLOTS];
  slot_entry_t rd_entry_q;
  logic [SLOTS-1:0] busy_q, busy_d;
  logic rd_busy_q;

  // Entry contents are only meaningful while the slot's busy flag is set.
  always_ff @(posedge clk_i) begin
    if (ctl_i.set) begin
      slot_mem_q[wr_idx_i] <= wr_entry_i;
    end
    rd_entry_q <= slot_mem_q[rd_idx_i];
  end

  always_comb begin
    busy_d = busy_q;
    if (ctl_i.set) begin
      busy_d[wr_idx_i] = 1'b1;
    end else if (ctl_i.clr) begin
      busy_d[wr_idx_i] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= '0;
      rd_busy_q <= 1'b0;
    end else begin
      busy_q    <= busy_d;
      rd_busy_q <= busy_q[rd_idx_i];
    end
  end

  assign rd_entry_o = rd_entry_q;
  assign rd_busy_o  = rd_busy_q;

endmodule

>>> src/ptrt_scan_ctrl.sv
module ptrt_scan_ctrl import ptrt_pkg::*; #(
  parameter int SLOTS = SlotsDefault,
  parameter int IdxW  = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            op_i,
  input  logic [TagW-1:0] key_i,
  input  slot_entry_t     rd_entry_i,
  input  logic            rd_busy_i,
  input  logic            out_free_i,
  output logic [IdxW-1:0] rd_idx_o,
  output logic            busy_o,
  output scan_res_t       res_o,
  output logic [IdxW-1:0] hit_idx_o,
  output slot_entry_t     hit_entry_o
);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOTS - 1);

  scan_state_e state_q, state_d;
  logic [IdxW-1:0] addr_q, addr_d;
  logic issue_q, issue_d;
  logic cmp_vld_q, cmp_vld_d;
  logic [IdxW-1:0] cmp_idx_q, cmp_idx_d;
  logic hit_q, hit_d;
  logic [IdxW-1:0] hit_idx_q, hit_idx_d;
  slot_entry_t hit_entry_q, hit_entry_d;
  logic match, last, scan_end;

  // A command wants a free slot; a status wants a busy slot with its tag.
  assign match = cmp_vld_q &&
                 ((op_i == OP_CMD) ? !rd_busy_i : (rd_busy_i && (rd_entry_i.tag == key_i)));
  assign last     = cmp_vld_q && (cmp_idx_q == LastIdx);
  assign scan_end = match || last;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    busy_o     = (state_q != ST_IDLE);
    res_o.commit = (state_q == ST_FINISH) && out_free_i;
    res_o.hit  = hit_q;
  end

  // The compare sees each address in the cycle after it is issued, because the
  // table read data is registered.
  always_comb begin
    addr_d      = addr_q;
    issue_d     = issue_q;
    cmp_vld_d   = 1'b0;
    cmp_idx_d   = addr_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    hit_entry_d = hit_entry_q;
    if (state_q == ST_IDLE) begin
      addr_d  = '0;
      issue_d = start_i;
    end else if (state_q == ST_SCAN) begin
      if (scan_end) begin
        issue_d     = 1'b0;
        hit_d       = match;
        hit_idx_d   = cmp_idx_q;
        hit_entry_d = rd_entry_i;
      end else begin
        cmp_vld_d = issue_q;
        if (issue_q) begin
          if (addr_q == LastIdx) begin
            issue_d = 1'b0;
          end else begin
            addr_d = addr_q + IdxW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      addr_q    <= '0;
      issue_q   <= 1'b0;
      cmp_vld_q <= 1'b0;
      cmp_idx_q <= '0;
      hit_q     <= 1'b0;
      hit_idx_q <= '0;
    end else begin
      state_q   <= state_d;
      addr_q    <= addr_d;
      issue_q   <= issue_d;
      cmp_vld_q <= cmp_vld_d;
      cmp_idx_q <= cmp_idx_d;
      hit_q     <= hit_d;
      hit_idx_q <= hit_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_entry_q <= hit_entry_d;
  end

  assign rd_idx_o    = addr_q;
  assign hit_idx_o   = hit_idx_q;
  assign hit_entry_o = hit_entry_q;

endmodule

>>> src/pending_tag_remap_table.sv
// A result is registered once its slot scan has ended and the output is free;
// the slot scan visits one table entry per cycle through a single read port.
// Items are handled one at a time: a new item is taken only after the last
// result is committed, which waits while the output stalls and a result is held.
// Reset: all slots free, tag counter at 1, error code 4; no clearing pass.
module pending_tag_remap_table import ptrt_pkg::*; #(
  parameter int SLOTS = SlotsDefault,
  parameter int PORTS = PortsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [RespW-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             opcode_i,
  input  logic [PortW-1:0] port_index_i,
  input  logic [CtxW-1:0]  context_value_i,
  input  logic [CodeW-1:0] command_code_i,
  input  logic [RespW-1:0] response_code_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             destination_o,
  output logic [PortW-1:0] out_port_o,
  output logic [CtxW-1:0]  out_context_o,
  output logic [CodeW-1:0] out_code_o,
  output logic [RespW-1:0] out_response_o
);

  localparam int IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [RespW-1:0] err_code_q;
  logic [TagW-1:0]  next_tag_q, next_tag_d, tag_inc;

  logic             op_q;
  logic [PortW-1:0] port_q, port_red;
  logic [CtxW-1:0]  ctx_q;
  logic [CodeW-1:0] code_q;
  logic [RespW-1:0] resp_q;

  logic             in_accept, out_free, scan_busy;
  tbl_ctl_t         tbl_ctl;
  slot_entry_t      wr_entry, rd_entry, hit_entry;
  logic             rd_busy;
  logic [IdxW-1:0]  rd_idx, hit_idx;
  scan_res_t        scan_res;

  logic             out_valid_q, out_valid_d;
  logic             dest_q, dest_d;
  logic [PortW-1:0] oport_q, oport_d;
  logic [CtxW-1:0]  octx_q, octx_d;
  logic [CodeW-1:0] ocode_q;
  logic [RespW-1:0] oresp_q, oresp_d;

  assign in_stall_o = scan_busy;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Fold a port number beyond the port count back into range.
  always_comb begin
    port_red = port_index_i;
    for (int k = 0; k < 4; k++) begin
      if (int'(port_red) >= PORTS) begin
        port_red = PortW'(int'(port_red) - PORTS);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q   <= opcode_i;
      port_q <= port_red;
      ctx_q  <= context_value_i;
      code_q <= command_code_i;
      resp_q <= response_code_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_code_q <= ErrCodeReset;
    end else if (cfg_we_i) begin
      err_code_q <= cfg_wdata_i;
    end
  end

  ptrt_scan_ctrl #(
    .SLOTS (SLOTS),
    .IdxW  (IdxW)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_accept),
    .op_i        (op_q),
    .key_i       (ctx_q),
    .rd_entry_i  (rd_entry),
    .rd_busy_i   (rd_busy),
    .out_free_i  (out_free),
    .rd_idx_o    (rd_idx),
    .busy_o      (scan_busy),
    .res_o       (scan_res),
    .hit_idx_o   (hit_idx),
    .hit_entry_o (hit_entry)
  );

  always_comb begin
    tbl_ctl.set    = scan_res.commit && scan_res.hit && (op_q == OP_CMD);
    tbl_ctl.clr    = scan_res.commit && scan_res.hit && (op_q == OP_STS);
    wr_entry.tag   = next_tag_q;
    wr_entry.ctx   = ctx_q;
    wr_entry.port  = port_q;
  end

  ptrt_slot_table #(
    .SLOTS (SLOTS),
    .IdxW  (IdxW)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (tbl_ctl),
    .wr_idx_i   (hit_idx),
    .wr_entry_i (wr_entry),
    .rd_idx_i   (rd_idx),
    .rd_entry_o (rd_entry),
    .rd_busy_o  (rd_busy)
  );

  // The tag counter wraps past zero straight to one.
  assign tag_inc = next_tag_q + TagW'(1);
  always_comb begin
    next_tag_d = next_tag_q;
    if (tbl_ctl.set) begin
      next_tag_d = (tag_inc == '0) ? TagFirst : tag_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_tag_q <= TagFirst;
    end else begin
      next_tag_q <= next_tag_d;
    end
  end

  always_comb begin
    dest_d  = DEST_STATUS;
    oport_d = '0;
    octx_d  = ctx_q;
    oresp_d = resp_q;
    if (op_q == OP_CMD) begin
      if (scan_res.hit) begin
        dest_d  = DEST_DISPATCH;
        octx_d  = next_tag_q;
        oresp_d = '0;
      end else begin
        oport_d = port_q;
        oresp_d = err_code_q;
      end
    end else if (scan_res.hit) begin
      oport_d = hit_entry.port;
      octx_d  = hit_entry.ctx;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (scan_res.commit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_res.commit) begin
      dest_q  <= dest_d;
      oport_q <= oport_d;
      octx_q  <= octx_d;
      ocode_q <= code_q;
      oresp_q <= oresp_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign destination_o  = dest_q;
  assign out_port_o     = oport_q;
  assign out_context_o  = octx_q;
  assign out_code_o     = ocode_q;
  assign out_response_o = oresp_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("scan sequencer did not go busy after an accepted beat");

  a_out_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(scan_res.commit))
    else $error("result appeared without a committed scan");

  a_tag_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_tag_q != '0)
    else $error("tag counter reached zero");

  a_dispatch_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (destination_o == DEST_DISPATCH)) |-> (out_context_o != '0))
    else $error("dispatched command carries tag zero");

endmodule

>>> dv/pending_tag_remap_table_checker.sv
module pending_tag_remap_table_checker import ptrt_pkg::*; #(
  parameter int SLOTS = SlotsDefault,
  parameter int PORTS = PortsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [RespW-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic             opcode_i,
  input  logic [PortW-1:0] port_index_i,
  input  logic [CtxW-1:0]  context_value_i,
  input  logic [CodeW-1:0] command_code_i,
  input  logic [RespW-1:0] response_code_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic             destination_i,
  input  logic [PortW-1:0] out_port_i,
  input  logic [CtxW-1:0]  out_context_i,
  input  logic [CodeW-1:0] out_code_i,
  input  logic [RespW-1:0] out_response_i,
  input  logic             done_i,
  output int               errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic             dest;
    logic [PortW-1:0] port;
    logic [CtxW-1:0]  ctx;
    logic [CodeW-1:0] code;
    logic [RespW-1:0] resp;
  } remap_result_t;

  // Shadow copy of the remap table.
  logic             slot_busy  [SLOTS];
  logic [TagW-1:0]  slot_tag   [SLOTS];
  logic [CtxW-1:0]  slot_ctx   [SLOTS];
  logic [PortW-1:0] slot_port  [SLOTS];
  logic [TagW-1:0]  next_tag;
  logic [RespW-1:0] exec_err_code;

  remap_result_t pending_results[$];
  remap_result_t predicted;
  remap_result_t oldest;

  int mismatches;
  int n_dispatch;
  int n_full;
  int n_hit;
  int n_unknown;
  int n_cfg;
  bit done_seen;

  assign errors_o = mismatches;

  task automatic report_mismatch(input string what, input logic [CtxW-1:0] got,
                                 input logic [CtxW-1:0] want);
    mismatches++;
    if (mismatches <= 40) begin
      $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
    end
  endtask

  task automatic clear_table();
    for (int i = 0; i < SLOTS; i++) begin
      slot_busy[i] = 1'b0;
      slot_tag[i]  = '0;
      slot_ctx[i]  = '0;
      slot_port[i] = '0;
    end
    next_tag = TagFirst;
    exec_err_code = ErrCodeReset;
  endtask

  task automatic remap_beat(input logic op, input logic [PortW-1:0] port_in,
                            input logic [CtxW-1:0] ctx, input logic [CodeW-1:0] code,
                            input logic [RespW-1:0] resp, output remap_result_t res);
    int free_slot;
    int hit_slot;
    logic [PortW-1:0] port;
    port = PortW'(int'(port_in) % PORTS);
    free_slot = -1;
    hit_slot = -1;
    res.code = code;
    if (op == OP_CMD) begin
      for (int i = SLOTS - 1; i >= 0; i--) begin
        if (!slot_busy[i]) free_slot = i;
      end
      if (free_slot >= 0) begin
        slot_busy[free_slot] = 1'b1;
        slot_tag[free_slot]  = next_tag;
        slot_ctx[free_slot]  = ctx;
        slot_port[free_slot] = port;
        res.dest = DEST_DISPATCH;
        res.port = '0;
        res.ctx  = next_tag;
        res.resp = '0;
        // The tag counter wraps past zero straight to one.
        next_tag = next_tag + 1'b1;
        if (next_tag == '0) next_tag = TagFirst;
        n_dispatch++;
      end else begin
        res.dest = DEST_STATUS;
        res.port = port;
        res.ctx  = ctx;
        res.resp = exec_err_code;
        n_full++;
      end
    end else begin
      for (int i = SLOTS - 1; i >= 0; i--) begin
        if (slot_busy[i] && slot_tag[i] == ctx) hit_slot = i;
      end
      res.dest = DEST_STATUS;
      res.resp = resp;
      if (hit_slot >= 0) begin
        res.port = slot_port[hit_slot];
        res.ctx  = slot_ctx[hit_slot];
        slot_busy[hit_slot] = 1'b0;
        slot_tag[hit_slot]  = '0;
        slot_ctx[hit_slot]  = '0;
        slot_port[hit_slot] = '0;
        n_hit++;
      end else begin
        res.port = '0;
        res.ctx  = ctx;
        n_unknown++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_table();
      pending_results.delete();
    end else begin
      if (cfg_we_i) begin
        exec_err_code = cfg_wdata_i;
        n_cfg++;
      end
      if (in_valid_i && !in_stall_i) begin
        remap_beat(opcode_i, port_index_i, context_value_i, command_code_i,
                   response_code_i, predicted);
        pending_results.push_back(predicted);
      end
      if (out_valid_i && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result beat with nothing expected, context", out_context_i, '0);
        end else begin
          oldest = pending_results.pop_front();
          if (destination_i !== oldest.dest)
            report_mismatch("destination", destination_i, oldest.dest);
          if (out_port_i !== oldest.port)
            report_mismatch("out_port", out_port_i, oldest.port);
          if (out_context_i !== oldest.ctx)
            report_mismatch("out_context", out_context_i, oldest.ctx);
          if (out_code_i !== oldest.code)
            report_mismatch("out_code", out_code_i, oldest.code);
          if (out_response_i !== oldest.resp)
            report_mismatch("out_response", out_response_i, oldest.resp);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (done_i && !done_seen) begin
      done_seen = 1'b1;
      if (pending_results.size() != 0)
        report_mismatch("results never delivered, count", pending_results.size(), 0);
      $display("covered %0d dispatches, %0d full-table rejects, %0d tag matches, %0d unknown tags, %0d error-code writes",
               n_dispatch, n_full, n_hit, n_unknown, n_cfg);
    end
  end

endmodule

>>> dv/pending_tag_remap_table_tb.sv
module pending_tag_remap_table_tb import ptrt_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Slots      = SlotsDefault;
  localparam int Ports      = PortsDefault;
  localparam int Phases     = 5;
  localparam int PhaseBeats = 400;
  localparam int HoldCycles = 300;
  localparam int CycleLimit = 500000;

  logic             clk_i;
  logic             rst_n;
  logic             cfg_we;
  logic [RespW-1:0] cfg_wdata;
  logic             in_valid;
  logic             in_stall;
  logic             opcode;
  logic [PortW-1:0] port_index;
  logic [CtxW-1:0]  context_value;
  logic [CodeW-1:0] command_code;
  logic [RespW-1:0] response_code;
  logic             out_valid;
  logic             out_stall;
  logic             rx_stall;
  logic             hold_stall;
  logic             destination;
  logic [PortW-1:0] out_port;
  logic [CtxW-1:0]  out_context;
  logic [CodeW-1:0] out_code;
  logic [RespW-1:0] out_response;
  logic             done;
  int               errors;

  // Tags that have been dispatched and not yet answered by a status beat.
  logic [TagW-1:0] live_tags[$];
  int beats_sent;
  int results_seen;
  int cycles;
  bit quiet;

  assign out_stall = rx_stall | hold_stall;

  pending_tag_remap_table #(
    .SLOTS(Slots),
    .PORTS(Ports)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .opcode_i       (opcode),
    .port_index_i   (port_index),
    .context_value_i(context_value),
    .command_code_i (command_code),
    .response_code_i(response_code),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .destination_o  (destination),
    .out_port_o     (out_port),
    .out_context_o  (out_context),
    .out_code_o     (out_code),
    .out_response_o (out_response)
  );

  pending_tag_remap_table_checker #(
    .SLOTS(Slots),
    .PORTS(Ports)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .opcode_i       (opcode),
    .port_index_i   (port_index),
    .context_value_i(context_value),
    .command_code_i (command_code),
    .response_code_i(response_code),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .destination_i  (destination),
    .out_port_i     (out_port),
    .out_context_i  (out_context),
    .out_code_i     (out_code),
    .out_response_i (out_response),
    .done_i         (done),
    .errors_o       (errors)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (destination == DEST_DISPATCH) live_tags.push_back(out_context);
    end
  end

  // Result side: random back-pressure per beat.
  initial begin
    int n;
    forever begin
      n = quiet ? 0 : $urandom_range(0, 6);
      if (n > 0) begin
        rx_stall <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      rx_stall <= 1'b0;
      do @(posedge clk_i); while (!(out_valid && !out_stall));
    end
  end

  // One long hold on the result side while the input side keeps offering beats.
  initial begin
    hold_stall <= 1'b0;
    wait (beats_sent >= 700);
    @(posedge clk_i);
    hold_stall <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_stall <= 1'b0;
  end

  task automatic send_beat(input logic op, input logic [PortW-1:0] port,
                           input logic [CtxW-1:0] ctx, input logic [CodeW-1:0] code,
                           input logic [RespW-1:0] resp);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid      <= 1'b1;
    opcode        <= op;
    port_index    <= port;
    context_value <= ctx;
    command_code  <= code;
    response_code <= resp;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    beats_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (results_seen != beats_sent) @(posedge clk_i);
    repeat (Slots + 4) @(posedge clk_i);
  endtask

  task automatic write_err_code(input logic [RespW-1:0] code);
    cfg_we    <= 1'b1;
    cfg_wdata <= code;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_beat(input int sts_pct);
    int r;
    int idx;
    logic [CtxW-1:0] ctx;
    logic [CodeW-1:0] code;
    r = $urandom_range(0, 99);
    code = ($urandom_range(0, 9) == 0) ? '0 :
           ($urandom_range(0, 19) == 0) ? '1 : CodeW'($urandom);
    if (r < sts_pct) begin
      r = $urandom_range(0, 99);
      if (live_tags.size() > 0 && r < 80) begin
        idx = $urandom_range(0, live_tags.size() - 1);
        ctx = live_tags[idx];
        live_tags.delete(idx);
      end else if (r < 85) begin
        ctx = '0;
      end else if (r < 90) begin
        ctx = '1;
      end else if (r < 95) begin
        // Small values land near recently used tags.
        ctx = CtxW'($urandom_range(1, 64));
      end else begin
        ctx = CtxW'($urandom);
      end
      send_beat(OP_STS, PortW'($urandom_range(0, 3)), ctx, code,
                RespW'($urandom_range(0, 15)));
    end else begin
      r = $urandom_range(0, 9);
      ctx = (r == 0) ? '0 : (r == 1) ? '1 : CtxW'($urandom);
      send_beat(OP_CMD, PortW'($urandom_range(0, 3)), ctx, code,
                RespW'($urandom_range(0, 15)));
    end
  endtask

  initial begin
    logic [RespW-1:0] err_plan[Phases];
    int sts_plan[Phases];
    logic [TagW-1:0] drain_tags[8];
    logic [CtxW-1:0] ctx;
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    in_valid      <= 1'b0;
    opcode        <= OP_CMD;
    port_index    <= '0;
    context_value <= '0;
    command_code  <= '0;
    response_code <= '0;
    done          <= 1'b0;
    quiet = 1'b0;
    err_plan = '{4'hF, 4'h0, RespW'($urandom_range(1, 14)), 4'h9, ErrCodeReset};
    sts_plan = '{35, 60, 75, 45, 55};
    drain_tags = '{32'd9, 32'd1, 32'd2, 32'd3, 32'd5, 32'd6, 32'd7, 32'd8};
    repeat (10) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Directed: empty-table status, fill all slots, overflow, free and reuse,
    // stale and extreme tags, then drain the table again.
    send_beat(OP_STS, 2'd3, '0, '1, 4'hF);
    for (int k = 0; k < 8; k++) begin
      ctx = (k == 0) ? '0 : (k == 1) ? '1 : CtxW'($urandom);
      send_beat(OP_CMD, PortW'(k), ctx, (k == 0) ? '0 : (k == 1) ? '1 : CodeW'($urandom),
                RespW'(k));
    end
    send_beat(OP_CMD, 2'd2, 32'hDEAD_0001, 32'h1, 4'h7);
    send_beat(OP_STS, 2'd1, 32'd4, 32'h2, 4'h0);
    send_beat(OP_CMD, 2'd3, 32'h1234_5678, '0, 4'h0);
    send_beat(OP_STS, 2'd0, 32'd4, 32'h3, 4'h5);
    send_beat(OP_STS, 2'd2, '1, 32'h4, 4'hA);
    foreach (drain_tags[k]) begin
      send_beat(OP_STS, PortW'($urandom_range(0, 3)), drain_tags[k], CodeW'($urandom),
                RespW'($urandom_range(0, 15)));
    end
    wait_drained();
    live_tags.delete();

    for (int ph = 0; ph < Phases; ph++) begin
      wait_drained();
      write_err_code(err_plan[ph]);
      for (int n = 0; n < PhaseBeats; n++) begin
        if (n % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
        random_beat(sts_plan[ph]);
      end
    end
    quiet = 1'b0;
    wait_drained();
    repeat (20) @(posedge clk_i);
    done <= 1'b1;
    repeat (2) @(posedge clk_i);
    $display("%0d input beats accepted, %0d result beats, %0d cycles", beats_sent,
             results_seen, cycles);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> pending_tag_remap_table.f
src/ptrt_pkg.sv
src/ptrt_slot_table.sv
src/ptrt_scan_ctrl.sv
src/pending_tag_remap_table.sv
dv/pending_tag_remap_table_checker.sv
dv/pending_tag_remap_table_tb.sv
